// ===== design/qvr_pkg.sv =====
// Shared widths, types and rounding helpers for the quaternion vector rotator.
package qvr_pkg;

  localparam int FRAC_BITS  = 14;
  localparam int DATA_W     = 16;
  localparam int SQ_W       = 32;
  localparam int RAD_W      = 62;
  localparam int ROOT_W     = 31;
  localparam int REM_W      = 34;
  localparam int NUM_SHIFT  = FRAC_BITS + 15;
  localparam int NUM_W      = 46;
  localparam int DIV_STAGES = 16;
  localparam int UNIT_W     = DIV_STAGES + 1;
  localparam int T_W        = 20;
  localparam int ACC_W      = 40;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROT_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROT_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROT_Z = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROT_W = 2'd3;

  // Magnitudes and signs that ride alongside the square root.
  typedef struct packed {
    logic [DATA_W-1:0] mag_x;
    logic [DATA_W-1:0] mag_y;
    logic [DATA_W-1:0] mag_z;
    logic              neg_x;
    logic              neg_y;
    logic              neg_z;
    logic              zero;
  } vec_side_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] z;
    logic signed [DATA_W-1:0] w;
  } quat_t;

  // Drops FRAC_BITS bits, rounding the magnitude half up.
  function automatic logic signed [ACC_W-1:0] round_drop(input logic signed [ACC_W-1:0] x);
    logic              neg;
    logic [ACC_W-1:0]  mag;
    neg = x[ACC_W-1];
    mag = neg ? ACC_W'(-x) : ACC_W'(x);
    mag = (mag + (ACC_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    return neg ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic signed [DATA_W-1:0] sat16(input logic signed [ACC_W-1:0] x);
    logic signed [DATA_W-1:0] r;
    if (x > ACC_W'(32767)) begin
      r = 16'sh7fff;
    end else if (x < -ACC_W'(32768)) begin
      r = 16'sh8000;
    end else begin
      r = x[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== design/qvr_if.sv =====
// Stream interfaces for input vectors and rotated result vectors.
interface qvr_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [qvr_pkg::DATA_W-1:0] vec_x;
  logic signed [qvr_pkg::DATA_W-1:0] vec_y;
  logic signed [qvr_pkg::DATA_W-1:0] vec_z;
  modport source (output valid, vec_x, vec_y, vec_z, input ready);
  modport sink (input valid, vec_x, vec_y, vec_z, output ready);
endinterface

interface qvr_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [qvr_pkg::DATA_W-1:0] out_x;
  logic signed [qvr_pkg::DATA_W-1:0] out_y;
  logic signed [qvr_pkg::DATA_W-1:0] out_z;
  modport source (output valid, out_x, out_y, out_z, input ready);
  modport sink (input valid, out_x, out_y, out_z, output ready);
endinterface

// ===== design/qvr_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module qvr_sqrt (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic [qvr_pkg::SQ_W-1:0]        rad_i,
  input  qvr_pkg::vec_side_t              side_i,
  output logic                            valid_o,
  output logic [qvr_pkg::ROOT_W-1:0]      root_o,
  output qvr_pkg::vec_side_t              side_o
);

  localparam int N = qvr_pkg::ROOT_W;

  logic                         v_s    [N+1];
  logic [qvr_pkg::RAD_W-1:0]    x_s    [N+1];
  logic [qvr_pkg::REM_W-1:0]    rem_s  [N+1];
  logic [qvr_pkg::ROOT_W-1:0]   root_s [N+1];
  qvr_pkg::vec_side_t           side_s [N+1];

  assign v_s[0]    = valid_i;
  assign x_s[0]    = {rad_i, {(qvr_pkg::RAD_W - qvr_pkg::SQ_W){1'b0}}};
  assign rem_s[0]  = '0;
  assign root_s[0] = '0;
  assign side_s[0] = side_i;

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [qvr_pkg::REM_W-1:0] rem_n;
    logic [qvr_pkg::REM_W-1:0] trial;
    logic                      ge;

    always_comb begin
      rem_n = {rem_s[k][qvr_pkg::REM_W-3:0], x_s[k][qvr_pkg::RAD_W-1 -: 2]};
      trial = qvr_pkg::REM_W'({root_s[k], 2'b01});
      ge    = rem_n >= trial;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_s[k+1] <= 1'b0;
      end else if (en_i) begin
        v_s[k+1] <= v_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_s[k+1]    <= x_s[k] << 2;
        rem_s[k+1]  <= ge ? rem_n - trial : rem_n;
        root_s[k+1] <= {root_s[k][qvr_pkg::ROOT_W-2:0], ge};
        side_s[k+1] <= side_s[k];
      end
    end
  end

  assign valid_o = v_s[N];
  assign root_o  = root_s[N];
  assign side_o  = side_s[N];

endmodule

// ===== design/qvr_div.sv =====
// Pipelined restoring divider that scales one component to unit length.
module qvr_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic [qvr_pkg::DATA_W-1:0]          mag_i,
  input  logic                                neg_i,
  input  logic                                zero_i,
  input  logic [qvr_pkg::ROOT_W-1:0]          den_i,
  output logic                                valid_o,
  output logic signed [qvr_pkg::UNIT_W-1:0]   unit_o
);

  localparam int N = qvr_pkg::DIV_STAGES;

  logic                         v_s   [N+1];
  logic [qvr_pkg::NUM_W-1:0]    rem_s [N+1];
  logic [qvr_pkg::ROOT_W-1:0]   den_s [N+1];
  logic [N-1:0]                 quo_s [N+1];
  logic                         neg_s [N+1];
  logic                         zer_s [N+1];

  // The rounding offset of half the divisor is added up front.
  assign v_s[0]   = valid_i;
  assign rem_s[0] = qvr_pkg::NUM_W'({mag_i, {qvr_pkg::NUM_SHIFT{1'b0}}})
                  + qvr_pkg::NUM_W'(den_i >> 1);
  assign den_s[0] = den_i;
  assign quo_s[0] = '0;
  assign neg_s[0] = neg_i;
  assign zer_s[0] = zero_i;

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [qvr_pkg::NUM_W-1:0] cmp;
    logic                      ge;

    always_comb begin
      cmp = qvr_pkg::NUM_W'(den_s[k]) << (N - 1 - k);
      ge  = rem_s[k] >= cmp;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_s[k+1] <= 1'b0;
      end else if (en_i) begin
        v_s[k+1] <= v_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_s[k+1] <= ge ? rem_s[k] - cmp : rem_s[k];
        quo_s[k+1] <= {quo_s[k][N-2:0], ge};
        den_s[k+1] <= den_s[k];
        neg_s[k+1] <= neg_s[k];
        zer_s[k+1] <= zer_s[k];
      end
    end
  end

  // A zero vector has no direction; its unit components are forced to zero.
  assign valid_o = v_s[N];
  assign unit_o  = zer_s[N] ? '0
                 : (neg_s[N] ? -$signed({1'b0, quo_s[N]}) : $signed({1'b0, quo_s[N]}));

endmodule

// ===== design/qvr_mul.sv =====
// Two Hamilton products, each a product stage followed by a sum-and-round stage.
module qvr_mul (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic signed [qvr_pkg::UNIT_W-1:0]   ux_i,
  input  logic signed [qvr_pkg::UNIT_W-1:0]   uy_i,
  input  logic signed [qvr_pkg::UNIT_W-1:0]   uz_i,
  input  qvr_pkg::quat_t                      rot_i,
  output logic                                valid_o,
  output logic signed [qvr_pkg::DATA_W-1:0]   out_x_o,
  output logic signed [qvr_pkg::DATA_W-1:0]   out_y_o,
  output logic signed [qvr_pkg::DATA_W-1:0]   out_z_o
);

  localparam int P1_W = qvr_pkg::UNIT_W + qvr_pkg::DATA_W;
  localparam int P2_W = qvr_pkg::T_W + qvr_pkg::DATA_W;

  logic [3:0] v_q;

  // u_i times q_j, index [i][j] with j = x, y, z, w.
  logic signed [P1_W-1:0] p1_q [3][4];
  logic signed [qvr_pkg::T_W-1:0] tx_q, ty_q, tz_q, tw_q;
  // q_j times t_k, index [j][k] with both = x, y, z, w.
  logic signed [P2_W-1:0] p2_q [4][4];

  logic signed [qvr_pkg::UNIT_W-1:0] u [3];
  logic signed [qvr_pkg::DATA_W-1:0] q [4];
  logic signed [qvr_pkg::T_W-1:0]    t [4];
  logic signed [qvr_pkg::ACC_W-1:0]  sx, sy, sz, sw, rx, ry, rz;

  always_comb begin
    u[0] = ux_i; u[1] = uy_i; u[2] = uz_i;
    q[0] = rot_i.x; q[1] = rot_i.y; q[2] = rot_i.z; q[3] = rot_i.w;
    t[0] = tx_q; t[1] = ty_q; t[2] = tz_q; t[3] = tw_q;
    sx = qvr_pkg::ACC_W'(p1_q[0][3]) - qvr_pkg::ACC_W'(p1_q[1][2])
       + qvr_pkg::ACC_W'(p1_q[2][1]);
    sy = qvr_pkg::ACC_W'(p1_q[1][3]) - qvr_pkg::ACC_W'(p1_q[2][0])
       + qvr_pkg::ACC_W'(p1_q[0][2]);
    sz = qvr_pkg::ACC_W'(p1_q[2][3]) - qvr_pkg::ACC_W'(p1_q[0][1])
       + qvr_pkg::ACC_W'(p1_q[1][0]);
    sw = qvr_pkg::ACC_W'(p1_q[0][0]) + qvr_pkg::ACC_W'(p1_q[1][1])
       + qvr_pkg::ACC_W'(p1_q[2][2]);
    rx = qvr_pkg::ACC_W'(p2_q[3][0]) + qvr_pkg::ACC_W'(p2_q[0][3])
       + qvr_pkg::ACC_W'(p2_q[1][2]) - qvr_pkg::ACC_W'(p2_q[2][1]);
    ry = qvr_pkg::ACC_W'(p2_q[3][1]) + qvr_pkg::ACC_W'(p2_q[1][3])
       + qvr_pkg::ACC_W'(p2_q[2][0]) - qvr_pkg::ACC_W'(p2_q[0][2]);
    rz = qvr_pkg::ACC_W'(p2_q[3][2]) + qvr_pkg::ACC_W'(p2_q[2][3])
       + qvr_pkg::ACC_W'(p2_q[0][1]) - qvr_pkg::ACC_W'(p2_q[1][0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 4; j++) begin
          p1_q[i][j] <= P1_W'(u[i] * q[j]);
        end
      end
      tx_q <= qvr_pkg::T_W'(qvr_pkg::round_drop(sx));
      ty_q <= qvr_pkg::T_W'(qvr_pkg::round_drop(sy));
      tz_q <= qvr_pkg::T_W'(qvr_pkg::round_drop(sz));
      tw_q <= qvr_pkg::T_W'(qvr_pkg::round_drop(sw));
      for (int j = 0; j < 4; j++) begin
        for (int k = 0; k < 4; k++) begin
          p2_q[j][k] <= P2_W'(q[j] * t[k]);
        end
      end
      out_x_o <= qvr_pkg::sat16(qvr_pkg::round_drop(rx));
      out_y_o <= qvr_pkg::sat16(qvr_pkg::round_drop(ry));
      out_z_o <= qvr_pkg::sat16(qvr_pkg::round_drop(rz));
    end
  end

  assign valid_o = v_q[3];

endmodule

// ===== design/quaternion_vector_rotate.sv =====
// Top level of the quaternion vector rotator.
// The block normalizes each incoming vector to unit length and rotates it by
// the quaternion held in rot_x, rot_y, rot_z and rot_w, returning the result
// in Q1.14 with saturation. It takes one word per clock and delivers one word
// per clock while the output is not stalled. A word passes through the squares
// and their sum, the bit-per-stage square root, the bit-per-stage unit-length
// dividers and the two Hamilton products. The whole pipeline advances together,
// so a stalled result holds every stage in place and nothing is lost or
// repeated. A zero vector yields a zero result. The quaternion registers should
// be written only while no word is in flight.
module quaternion_vector_rotate (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [qvr_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [qvr_pkg::DATA_W-1:0]           cfg_data_i,
  qvr_in_if.sink                               in_i,
  qvr_out_if.source                            out_o
);

  logic en;
  assign en = !out_o.valid || out_o.ready;
  assign in_i.ready = en;

  // Quaternion registers; reset to the identity rotation.
  qvr_pkg::quat_t rot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q.x <= '0;
      rot_q.y <= '0;
      rot_q.z <= '0;
      rot_q.w <= qvr_pkg::DATA_W'(1 << qvr_pkg::FRAC_BITS);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        qvr_pkg::CFG_ROT_X: rot_q.x <= cfg_data_i;
        qvr_pkg::CFG_ROT_Y: rot_q.y <= cfg_data_i;
        qvr_pkg::CFG_ROT_Z: rot_q.z <= cfg_data_i;
        qvr_pkg::CFG_ROT_W: rot_q.w <= cfg_data_i;
        default: rot_q <= rot_q;
      endcase
    end
  end

  // Stage A squares each component; stage B sums them.
  logic                       a_valid_q, b_valid_q;
  logic [qvr_pkg::SQ_W-1:0]   sqx_q, sqy_q, sqz_q, n2_q;
  qvr_pkg::vec_side_t         a_side_q, b_side_q, a_side_d, b_side_d;

  always_comb begin
    a_side_d.neg_x = in_i.vec_x[qvr_pkg::DATA_W-1];
    a_side_d.neg_y = in_i.vec_y[qvr_pkg::DATA_W-1];
    a_side_d.neg_z = in_i.vec_z[qvr_pkg::DATA_W-1];
    a_side_d.mag_x = a_side_d.neg_x ? qvr_pkg::DATA_W'(-in_i.vec_x) : in_i.vec_x;
    a_side_d.mag_y = a_side_d.neg_y ? qvr_pkg::DATA_W'(-in_i.vec_y) : in_i.vec_y;
    a_side_d.mag_z = a_side_d.neg_z ? qvr_pkg::DATA_W'(-in_i.vec_z) : in_i.vec_z;
    a_side_d.zero  = 1'b0;
  end

  always_comb begin
    b_side_d      = a_side_q;
    b_side_d.zero = (a_side_q.mag_x == '0) && (a_side_q.mag_y == '0)
                    && (a_side_q.mag_z == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else if (en) begin
      a_valid_q <= in_i.valid;
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqx_q    <= qvr_pkg::SQ_W'(in_i.vec_x * in_i.vec_x);
      sqy_q    <= qvr_pkg::SQ_W'(in_i.vec_y * in_i.vec_y);
      sqz_q    <= qvr_pkg::SQ_W'(in_i.vec_z * in_i.vec_z);
      a_side_q <= a_side_d;
      n2_q     <= sqx_q + sqy_q + sqz_q;
      b_side_q <= b_side_d;
    end
  end

  // Vector length with 15 fraction bits.
  logic                         s_valid;
  logic [qvr_pkg::ROOT_W-1:0]   s_root;
  qvr_pkg::vec_side_t           s_side;

  qvr_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (b_valid_q),
    .rad_i   (n2_q),
    .side_i  (b_side_q),
    .valid_o (s_valid),
    .root_o  (s_root),
    .side_o  (s_side)
  );

  // One divider lane per component; all lanes move in lockstep.
  logic [2:0]                          d_valid;
  logic signed [qvr_pkg::UNIT_W-1:0]   ux, uy, uz;

  qvr_div u_div_x (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en), .valid_i (s_valid),
    .mag_i (s_side.mag_x), .neg_i (s_side.neg_x), .zero_i (s_side.zero),
    .den_i (s_root), .valid_o (d_valid[0]), .unit_o (ux)
  );

  qvr_div u_div_y (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en), .valid_i (s_valid),
    .mag_i (s_side.mag_y), .neg_i (s_side.neg_y), .zero_i (s_side.zero),
    .den_i (s_root), .valid_o (d_valid[1]), .unit_o (uy)
  );

  qvr_div u_div_z (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en), .valid_i (s_valid),
    .mag_i (s_side.mag_z), .neg_i (s_side.neg_z), .zero_i (s_side.zero),
    .den_i (s_root), .valid_o (d_valid[2]), .unit_o (uz)
  );

  // Rotation proper; its last stage is the output register.
  qvr_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (d_valid[0]),
    .ux_i    (ux),
    .uy_i    (uy),
    .uz_i    (uz),
    .rot_i   (rot_q),
    .valid_o (out_o.valid),
    .out_x_o (out_o.out_x),
    .out_y_o (out_o.out_y),
    .out_z_o (out_o.out_z)
  );

  // The three divider lanes must carry the same word at all times.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    d_valid[0] == d_valid[1] && d_valid[0] == d_valid[2])
    else $error("divider lanes out of step");

  // A held result freezes the pipeline, so the root stage keeps its word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=> $stable(s_valid) && $stable(s_root))
    else $error("pipeline advanced under a stall");

  // A vector entering stage B as zero must have a zero sum of squares.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_valid_q && b_side_q.zero) |-> (n2_q == '0))
    else $error("zero flag disagrees with the squared length");

endmodule
